// ===== hw/rtl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

   // width of one sorted element
   localparam int unsigned DATA_W = 32;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      S_LOAD      = 5'b00001,
      S_SETUP     = 5'b00010,
      S_MERGE     = 5'b00100,
      S_OUT_FETCH = 5'b01000,
      S_OUT       = 5'b10000
   } mse_state_type;

endpackage

// ===== hw/rtl/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// Element memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [mse_pkg::DATA_W-1:0]  wr_data,
   input  logic [AW-1:0]               rd_a_addr,
   input  logic [AW-1:0]               rd_b_addr,
   output logic [mse_pkg::DATA_W-1:0]  rd_a_data,
   output logic [mse_pkg::DATA_W-1:0]  rd_b_data
);

   logic [mse_pkg::DATA_W-1:0] mem [DEPTH];
   logic [mse_pkg::DATA_W-1:0] rd_a_data_ff;
   logic [mse_pkg::DATA_W-1:0] rd_b_data_ff;

   // write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read two entries per cycle, registered
   always_ff @(posedge clock) begin
      rd_a_data_ff <= mem[rd_a_addr];
      rd_b_data_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

// ===== hw/rtl/merge_sort_engine.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine
// Batch sorter: stable ascending sort of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Send a batch on req_*: one value per transaction, req_tlast on the final
//   one. Values beyond MAX_ITEMS are dropped; that batch then returns
//   rsp_tuser (overflow) high on every result.
//   After the final value the engine sorts with bottom-up merge passes that
//   ping-pong between two memories, then returns the batch on rsp_* in
//   ascending order, stable for equal values, with rsp_tlast on the last one.
// Flow, for a batch of n stored values:
//   loading writes each stored value to store A; sorting takes ceil(log2 n)
//   passes, each a setup state and then one element merged per cycle, set by
//   the single write port of each memory; output follows a fetch state and
//   runs at one result per cycle while rsp_tready is high.
//   req_tready is low from the final value until the last result is taken.
// Reset: synchronous; returns to loading with an empty batch.
// Stall: while rsp_tready is low the current result is held unchanged.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,   // last_out
   output logic        rsp_tuser    // [0] overflow
);

   localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
   localparam int unsigned WW = CW + 1;
   localparam int unsigned SW = CW + 2;
   localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

   mse_pkg::mse_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic          src_ff, src_in;      // 0: sorted data in store A
   logic [WW-1:0] w_ff, w_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] k_ff, k_in;

   logic [mse_pkg::DATA_W-1:0] a_rd_a, a_rd_b, b_rd_a, b_rd_b;
   logic [mse_pkg::DATA_W-1:0] da, db, wr_data;
   logic                       a_wr_en, b_wr_en;
   logic [AW-1:0]              a_wr_addr;

   logic          req_fire, rsp_fire, store_ok, take_a;
   logic [SW-1:0] n_w, pair_lo, mid_c, hi_c, k_nx;
   logic [WW-1:0] w_dbl;

   // element store (A) and merge buffer (B)
   mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store_a (
      .clock     (clock),
      .wr_en     (a_wr_en),
      .wr_addr   (a_wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (a_in[AW-1:0]),
      .rd_b_addr (b_in[AW-1:0]),
      .rd_a_data (a_rd_a),
      .rd_b_data (a_rd_b)
   );

   mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store_b (
      .clock     (clock),
      .wr_en     (b_wr_en),
      .wr_addr   (k_ff[AW-1:0]),
      .wr_data   (wr_data),
      .rd_a_addr (a_in[AW-1:0]),
      .rd_b_addr (b_in[AW-1:0]),
      .rd_a_data (b_rd_a),
      .rd_b_data (b_rd_b)
   );

   // select the current source memory
   assign da = src_ff ? b_rd_a : a_rd_a;
   assign db = src_ff ? b_rd_b : a_rd_b;

   // handshakes
   assign req_tready = (state_ff == mse_pkg::S_LOAD);
   assign rsp_tvalid = (state_ff == mse_pkg::S_OUT);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign store_ok   = (count_ff < CAP);

   // merge decision: earlier run wins on equal values
   assign take_a = (a_ff < mid_ff) &&
                   ((b_ff >= hi_ff) || ($signed(da) <= $signed(db)));

   // write ports
   assign wr_data   = (state_ff == mse_pkg::S_LOAD) ? req_tdata : (take_a ? da : db);
   assign a_wr_en   = (req_fire && store_ok) || ((state_ff == mse_pkg::S_MERGE) && src_ff);
   assign a_wr_addr = (state_ff == mse_pkg::S_LOAD) ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign b_wr_en   = (state_ff == mse_pkg::S_MERGE) && !src_ff;

   // run bounds of the next pair of runs
   assign n_w     = SW'(count_ff);
   assign pair_lo = (state_ff == mse_pkg::S_SETUP) ? '0 : SW'(hi_ff);
   assign mid_c   = pair_lo + SW'(w_ff);
   assign hi_c    = pair_lo + (SW'(w_ff) << 1);
   assign k_nx    = SW'(k_ff) + SW'(1);
   assign w_dbl   = w_ff << 1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      src_in   = src_ff;
      w_in     = w_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      k_in     = k_ff;
      case (state_ff)
         mse_pkg::S_LOAD: begin
            if (req_fire) begin
               if (store_ok) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  src_in = 1'b0;
                  w_in   = WW'(1);
                  a_in   = '0;
                  if (count_in <= CW'(1)) begin
                     state_in = mse_pkg::S_OUT_FETCH;
                  end else begin
                     state_in = mse_pkg::S_SETUP;
                  end
               end
            end
         end
         mse_pkg::S_SETUP: begin
            // issue the first reads of a pass
            a_in     = '0;
            mid_in   = (mid_c < n_w) ? mid_c[CW-1:0] : count_ff;
            b_in     = mid_in;
            hi_in    = (hi_c < n_w) ? hi_c[CW-1:0] : count_ff;
            k_in     = '0;
            state_in = mse_pkg::S_MERGE;
         end
         mse_pkg::S_MERGE: begin
            k_in = k_nx[CW-1:0];
            if (k_nx == n_w) begin
               // pass done: swap memories, double the run width
               src_in = !src_ff;
               w_in   = w_dbl;
               a_in   = '0;
               if (SW'(w_dbl) >= n_w) begin
                  state_in = mse_pkg::S_OUT_FETCH;
               end else begin
                  state_in = mse_pkg::S_SETUP;
               end
            end else if (k_nx == SW'(hi_ff)) begin
               // advance to the next pair of runs
               a_in   = hi_ff;
               mid_in = (mid_c < n_w) ? mid_c[CW-1:0] : count_ff;
               b_in   = mid_in;
               hi_in  = (hi_c < n_w) ? hi_c[CW-1:0] : count_ff;
            end else begin
               a_in = a_ff + CW'(take_a);
               b_in = b_ff + CW'(!take_a);
            end
         end
         mse_pkg::S_OUT_FETCH: begin
            a_in     = '0;
            state_in = mse_pkg::S_OUT;
         end
         mse_pkg::S_OUT: begin
            if (rsp_fire) begin
               if (SW'(a_ff) + SW'(1) == n_w) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = mse_pkg::S_LOAD;
               end else begin
                  a_in = a_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = mse_pkg::S_LOAD;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mse_pkg::S_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   // pass and pointer registers
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      w_ff   <= w_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      k_ff   <= k_in;
   end

   // result payload comes straight from the registered read port
   assign rsp_tdata = da;
   assign rsp_tlast = (SW'(a_ff) + SW'(1) == n_w);
   assign rsp_tuser = drop_ff;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the merge sort engine.
// ----------------------------------------------------------------------------
// Batches of signed values go in on req_*. A shadow sorter kept here orders
// each batch (stable, ascending, capacity-limited) and every result
// transaction on rsp_* is compared field by field with the oldest expected
// one. A short table opens the run: single values at the extremes, a full
// and an over-full batch of one value, and two mixed batches. Random
// batches follow, mostly small with an occasional large one that may be
// over-full, under changing idle and stall patterns. One long receiver
// hold-off backs the engine up, and the sender drains it once before going on.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned MAX_ITEMS   = 64;
   localparam int unsigned RAND_ITEMS  = 230;
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned TAIL_CYCLES = 20;

   // one table row: reps copies of value, the final copy marked last when last is set
   typedef struct {
      logic [mse_pkg::DATA_W-1:0] value;
      int unsigned                reps;
      bit                         last;
      bit                         typed;
      int unsigned                exp_n;
      logic [mse_pkg::DATA_W-1:0] exp_value;
      bit                         exp_ovf;
   } stim_row_type;

   typedef struct packed {
      logic [mse_pkg::DATA_W-1:0] value;
      logic                       last;
      logic                       ovf;
   } sorted_item_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [mse_pkg::DATA_W-1:0] req_tdata = '0;
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [mse_pkg::DATA_W-1:0] rsp_tdata;
   logic                       rsp_tlast;
   logic                       rsp_tuser;

   // table expectations travel with the item they belong to
   logic                       tag_typed = 1'b0;
   int unsigned                tag_n = 0;
   logic [mse_pkg::DATA_W-1:0] tag_value = '0;
   logic                       tag_ovf = 1'b0;

   // shadow sorter state and expected results
   logic signed [mse_pkg::DATA_W-1:0] batch_vals[$];
   logic                              batch_dropped = 1'b0;
   sorted_item_type                   predicted[$];
   sorted_item_type                   due_results[$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_left = 0;

   int unsigned values_taken = 0;
   int unsigned batches_done = 0;
   int unsigned overflow_batches = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   logic            progress;
   sorted_item_type want;

   stim_row_type plan[0:11];

   merge_sort_engine #(.MAX_ITEMS(MAX_ITEMS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value
      .req_tlast  (req_tlast),   // last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] sorted_value
      .rsp_tlast  (rsp_tlast),   // last_out
      .rsp_tuser  (rsp_tuser)    // [0] overflow
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // store one value; on last, order the batch stably into predicted
   task automatic absorb_value(input logic [mse_pkg::DATA_W-1:0] v, input logic is_last);
      logic signed [mse_pkg::DATA_W-1:0] ordered[$];
      int unsigned pos;
      sorted_item_type r;
      if (batch_vals.size() < MAX_ITEMS) begin
         batch_vals = {batch_vals, v};
      end else begin
         batch_dropped = 1'b1;
      end
      if (!is_last) return;
      // insert after every equal value so arrival order is kept
      foreach (batch_vals[i]) begin
         pos = 0;
         while (pos < ordered.size() && ordered[pos] <= batch_vals[i]) pos++;
         ordered.insert(pos, batch_vals[i]);
      end
      predicted.delete();
      foreach (ordered[i]) begin
         r.value = ordered[i];
         r.last  = (i == ordered.size() - 1);
         r.ovf   = batch_dropped;
         predicted = {predicted, r};
      end
      batch_vals.delete();
      batch_dropped = 1'b0;
   endtask

   // offer one value, wait for the transaction
   task automatic send_value(input logic [mse_pkg::DATA_W-1:0] v, input logic is_last,
                             input logic typed, input int unsigned n,
                             input logic [mse_pkg::DATA_W-1:0] tv, input logic tovf);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= is_last;
      tag_typed  <= typed;
      tag_n      <= n;
      tag_value  <= tv;
      tag_ovf    <= tovf;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [mse_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3: pick_value = $urandom;
         4, 5, 6:    pick_value = $urandom_range(0, 15) - 8;
         7: begin
            case ($urandom_range(3))
               0:       pick_value = 32'h8000_0000;
               1:       pick_value = 32'h7fff_ffff;
               2:       pick_value = 32'h0000_0000;
               default: pick_value = 32'hffff_ffff;
            endcase
         end
         default:    pick_value = {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // predict on each input transaction, check each result transaction
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (req_tvalid && req_tready) begin
            progress = 1'b1;
            values_taken++;
            absorb_value(req_tdata, req_tlast);
            if (req_tlast) begin
               batches_done++;
               if (predicted.size() > 0 && predicted[0].ovf) overflow_batches++;
               if (tag_typed) begin
                  for (int unsigned i = 0; i < tag_n; i++) begin
                     want.value = tag_value;
                     want.last  = (i == tag_n - 1);
                     want.ovf   = tag_ovf;
                     due_results = {due_results, want};
                  end
               end else begin
                  foreach (predicted[i]) due_results = {due_results, predicted[i]};
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            progress = 1'b1;
            results_checked++;
            if (due_results.size() == 0) begin
               $error("unexpected result transaction: sorted_value %0d",
                      $signed(rsp_tdata));
               mismatches++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         $signed(want.value), $signed(rsp_tdata));
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_out: expected %0b, got %0b", want.last, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tuser !== want.ovf) begin
                  $error("overflow: expected %0b, got %0b", want.ovf, rsp_tuser);
                  mismatches++;
               end
            end
         end
         // watchdog: end the run when nothing moves for too long
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d cycles without a transaction", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int unsigned offered;
      int unsigned batch;
      int unsigned size;
      logic [mse_pkg::DATA_W-1:0] v;

      // single values come back unchanged
      plan[0]  = '{32'h8000_0000, 1,  1'b1, 1'b1, 1,  32'h8000_0000, 1'b0};
      plan[1]  = '{32'h7fff_ffff, 1,  1'b1, 1'b1, 1,  32'h7fff_ffff, 1'b0};
      plan[2]  = '{32'h0000_0000, 1,  1'b1, 1'b1, 1,  32'h0000_0000, 1'b0};
      plan[3]  = '{32'hffff_ffff, 1,  1'b1, 1'b1, 1,  32'hffff_ffff, 1'b0};
      // exactly full, then full with the last item dropped
      plan[4]  = '{32'h5555_5555, 64, 1'b1, 1'b1, 64, 32'h5555_5555, 1'b0};
      plan[5]  = '{32'haaaa_aaaa, 65, 1'b1, 1'b1, 64, 32'haaaa_aaaa, 1'b1};
      // mixed batch with duplicates and both extremes
      plan[6]  = '{32'h7fff_ffff, 1,  1'b0, 1'b0, 0,  '0, 1'b0};
      plan[7]  = '{32'hffff_fffd, 2,  1'b0, 1'b0, 0,  '0, 1'b0};
      plan[8]  = '{32'h8000_0000, 1,  1'b1, 1'b0, 0,  '0, 1'b0};
      // full store, with the last two items dropped
      plan[9]  = '{32'h1234_5678, 63, 1'b0, 1'b0, 0,  '0, 1'b0};
      plan[10] = '{32'h8000_0000, 2,  1'b0, 1'b0, 0,  '0, 1'b0};
      plan[11] = '{32'h0000_0000, 1,  1'b1, 1'b0, 0,  '0, 1'b0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (plan[r]) begin
         for (int unsigned k = 0; k < plan[r].reps; k++) begin
            send_value(plan[r].value, plan[r].last && (k == plan[r].reps - 1),
                       plan[r].typed, plan[r].exp_n, plan[r].exp_value, plan[r].exp_ovf);
         end
      end

      // random batches under rotating idle patterns
      offered = 0;
      batch = 0;
      while (offered < RAND_ITEMS) begin
         case ((batch / 4) % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         if ($urandom_range(15) == 0) size = $urandom_range(60, 70);
         else size = $urandom_range(1, 12);
         // back the engine up behind a long receiver hold-off
         if (batch == 3) begin
            size = 8;
            hold_left = HOLD_CYCLES;
         end
         for (int unsigned k = 0; k < size; k++) begin
            v = pick_value();
            send_value(v, k == size - 1, 1'b0, 0, '0, 1'b0);
         end
         offered += size;
         // drain the engine once before going on
         if (batch == 10) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (due_results.size() != 0) @(posedge clock);
         end
         batch++;
      end
      req_tvalid <= 1'b0;

      // let the last batch come out, then a quiet tail
      stall_pct = 0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sorted %0d values in %0d batches, %0d of them over capacity;",
               values_taken, batches_done, overflow_batches);
      $display("%0d results compared under mixed idle, stall and hold-off patterns.",
               results_checked);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/merge_sort_engine.sv
sim/tb_top.sv
